>>> rtl/kaes_pkg.sv
package kaes_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned KeyW     = 8;
  localparam int unsigned AngleW   = 8;
  localparam int unsigned CmpW     = 16;
  localparam int unsigned DebW     = 16;
  localparam int unsigned PulseW   = 15;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  localparam logic [KeyW-1:0]   KEY_HASH  = 8'd35;
  localparam logic [KeyW-1:0]   DIGIT_0   = 8'd48;
  localparam logic [KeyW-1:0]   DIGIT_9   = 8'd57;
  localparam logic [AngleW-1:0] ANGLE_MAX = 8'd180;
  // parse saturation: any partial value above this becomes too big for 180
  localparam logic [AngleW-1:0] PARSE_SAT_LIMIT = 8'd18;
  localparam logic [AngleW-1:0] PARSE_SAT_VALUE = 8'd181;

  // x / 180 == (x >> 2) / 45, and y / 45 == (y * RECIP_45) >> 27 for y < 2^21
  localparam int unsigned        RecipShift = 27;
  localparam logic [21:0]        RECIP_45   = 22'd2982617;
  localparam int unsigned        RecipHalfW = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_OFFSET   = 2'd1,
    CFG_SPAN     = 2'd2
  } cfg_idx_e;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_EVAL  = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_DLO   = 8'b0001_0000,
    ST_DHI   = 8'b0010_0000,
    ST_SUM   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic eval;
    logic mul;
    logic div_lo;
    logic div_hi;
    logic sum;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic upd_req;
    logic out_free;
  } dp_sts_t;

  // 4x4 keypad map, row r and column c
  function automatic logic [KeyW-1:0] key_lookup(input logic [1:0] r, input logic [1:0] c);
    logic [KeyW-1:0] k;
    k = 8'd0;
    unique case ({r, c})
      4'h0: k = 8'd68;
      4'h1: k = 8'd67;
      4'h2: k = 8'd66;
      4'h3: k = 8'd65;
      4'h4: k = 8'd35;
      4'h5: k = 8'd57;
      4'h6: k = 8'd54;
      4'h7: k = 8'd51;
      4'h8: k = 8'd48;
      4'h9: k = 8'd56;
      4'hA: k = 8'd53;
      4'hB: k = 8'd50;
      4'hC: k = 8'd42;
      4'hD: k = 8'd55;
      4'hE: k = 8'd52;
      4'hF: k = 8'd49;
      default: k = 8'd0;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/kaes_ctrl.sv
module kaes_ctrl
  import kaes_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.upd_req ? ST_MUL : ST_EMIT;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DLO;
      end
      ST_DLO: begin
        cmd_o.div_lo = 1'b1;
        state_d      = ST_DHI;
      end
      ST_DHI: begin
        cmd_o.div_hi = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // a completed entry always runs through the scaling steps
  a_upd_goes_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && sts_i.upd_req) |=> (state_q == ST_MUL))
    else $error("entry completion skipped scaling");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !sts_i.out_free) |=> (state_q == ST_EMIT))
    else $error("result dropped while output busy");

  a_ready_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK || state_q == ST_MUL) |-> !in_ready_o)
    else $error("input taken mid item");

endmodule

>>> rtl/kaes_dp.sv
module kaes_dp
  import kaes_pkg::*;
#(
  parameter int unsigned ENTRY_LENGTH = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [TimeW-1:0]    time_ms_i,
  input  logic [1:0]          column_i,
  input  logic [3:0]          row_sense_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic [KeyW-1:0]     key_code_o,
  output logic [1:0]          keys_held_o,
  output logic                servo_updated_o,
  output logic [AngleW-1:0]   angle_o,
  output logic [CmpW-1:0]     compare_value_o
);

  localparam int unsigned CntRawW = $clog2(ENTRY_LENGTH + 1);
  localparam int unsigned CntW    = (CntRawW > 2) ? CntRawW : 2;
  localparam logic [CntW-1:0] CntFull = CntW'(ENTRY_LENGTH);

  // configuration
  logic [DebW-1:0]   debounce_q;
  logic [PulseW-1:0] offset_q, span_q;

  // item registers
  logic [TimeW-1:0] time_q;
  logic [1:0]       col_q;
  logic [3:0]       rows_q;
  logic             accept_q, upd_q;

  // held state
  logic [TimeW-1:0]  last_time_q;
  logic [KeyW-1:0]   last_key_q;
  logic [KeyW-1:0]   chars_q [ENTRY_LENGTH];
  logic [CntW-1:0]   count_q;
  logic [AngleW-1:0] angle_q;
  logic [CmpW-1:0]   compare_q;

  // scaling
  logic [22:0] prod_q;
  logic [31:0] plo_q;
  logic [42:0] mac_q;
  logic [20:0] quarter;

  // output word
  logic              out_valid_q;
  logic              out_acc_q, out_upd_q;
  logic [KeyW-1:0]   out_key_q;
  logic [1:0]        out_held_q;
  logic [AngleW-1:0] out_angle_q;
  logic [CmpW-1:0]   out_cmp_q;

  // combinational evaluation
  logic [TimeW-1:0]  gap;
  logic [KeyW-1:0]   key_next;
  logic [KeyW-1:0]   chars_next [ENTRY_LENGTH];
  logic [CntW-1:0]   count_next;
  logic [AngleW-1:0] parse_v;
  logic              parse_stop;
  logic [AngleW-1:0] angle_next;
  logic              upd_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= 16'd10;
      offset_q   <= 15'd250;
      span_q     <= 15'd999;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE: debounce_q <= cfg_wdata_i;
        CFG_OFFSET:   offset_q   <= cfg_wdata_i[PulseW-1:0];
        CFG_SPAN:     span_q     <= cfg_wdata_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  assign gap = time_q - last_time_q;

  always_comb begin
    key_next = last_key_q;
    for (int r = 0; r < 4; r++) begin
      if (rows_q[r]) key_next = key_lookup(2'(r), col_q);
    end
    count_next = count_q;
    for (int i = 0; i < ENTRY_LENGTH; i++) begin
      chars_next[i] = chars_q[i];
      if (count_q == CntW'(i)) chars_next[i] = key_next;
    end
    if (count_q < CntFull) count_next = count_q + CntW'(1);

    // leading digits, saturated once the value cannot come back under 180
    parse_v    = '0;
    parse_stop = 1'b0;
    for (int i = 0; i < ENTRY_LENGTH; i++) begin
      if (!parse_stop) begin
        if (chars_next[i] >= DIGIT_0 && chars_next[i] <= DIGIT_9) begin
          if (parse_v > PARSE_SAT_LIMIT) parse_v = PARSE_SAT_VALUE;
          else parse_v = 8'(parse_v * 8'd10) + 8'(chars_next[i] - DIGIT_0);
        end else begin
          parse_stop = 1'b1;
        end
      end
    end
    angle_next = (parse_v > ANGLE_MAX) ? ANGLE_MAX : parse_v;
    upd_req    = accept_q && (count_next == CntFull) && (key_next == KEY_HASH);
  end

  assign quarter = prod_q[22:2];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      time_q <= time_ms_i;
      col_q  <= column_i;
      rows_q <= row_sense_i;
    end
    if (cmd_i.mul)    prod_q <= {15'd0, angle_q} * {8'd0, span_q};
    if (cmd_i.div_lo) plo_q  <= {11'd0, quarter} * {21'd0, RECIP_45[RecipHalfW-1:0]};
    if (cmd_i.div_hi) begin
      mac_q <= (({22'd0, quarter} * {32'd0, RECIP_45[21:RecipHalfW]}) << RecipHalfW)
               + {11'd0, plo_q};
    end
    if (cmd_i.emit) begin
      out_acc_q   <= accept_q;
      out_upd_q   <= upd_q;
      out_key_q   <= last_key_q;
      out_held_q  <= count_q[1:0];
      out_angle_q <= angle_q;
      out_cmp_q   <= compare_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_q    <= 1'b0;
      upd_q       <= 1'b0;
      last_time_q <= '0;
      last_key_q  <= '0;
      count_q     <= '0;
      angle_q     <= '0;
      compare_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRY_LENGTH; i++) chars_q[i] <= '0;
    end else begin
      if (cmd_i.check) accept_q <= gap > {16'd0, debounce_q};
      if (cmd_i.eval) begin
        upd_q <= upd_req;
        if (accept_q) begin
          last_time_q <= time_q;
          last_key_q  <= key_next;
          if (upd_req) begin
            angle_q <= angle_next;
            count_q <= '0;
            for (int i = 0; i < ENTRY_LENGTH; i++) chars_q[i] <= '0;
          end else begin
            count_q <= count_next;
            for (int i = 0; i < ENTRY_LENGTH; i++) chars_q[i] <= chars_next[i];
          end
        end
      end
      if (cmd_i.sum) compare_q <= {1'b0, offset_q} + {1'b0, mac_q[RecipShift+14:RecipShift]};
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.upd_req  = upd_req;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_acc_q;
  assign key_code_o      = out_key_q;
  assign keys_held_o     = out_held_q;
  assign servo_updated_o = out_upd_q;
  assign angle_o         = out_angle_q;
  assign compare_value_o = out_cmp_q;

  a_upd_needs_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_upd_q || out_acc_q))
    else $error("servo update without accepted event");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_q <= ANGLE_MAX)
    else $error("held angle above limit");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("entry count overrun");

  a_reject_keeps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && !accept_q) |=> $stable(last_time_q))
    else $error("rejected event changed timestamp");

endmodule

>>> rtl/keypad_angle_entry_servo.sv
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  time_ms, column, row_sense
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  accepted, key_code, keys_held,
//                                                 servo_updated, angle, compare_value
// cfg       in   cfg_we_i (no back-pressure)      0 debounce_ms, 1 pulse_offset, 2 pulse_span
//
// one event at a time: a plain event steps through check, evaluate and emit; a
// completed entry adds the angle*span product, two reciprocal partial products
// for the /180 and the offset add, all set by the single sequencer
// a new event is taken as soon as the previous result sits in the output register
// reset is asynchronous, active low; state, config and held registers reset at once
// a stalled output holds the sequencer in its final step until the word is taken
module keypad_angle_entry_servo
  import kaes_pkg::*;
#(
  parameter int unsigned ENTRY_LENGTH = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [31:0] time_ms, [33:32] column, [37:34] row_sense, [39:38] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] accepted, [8:1] key_code, [10:9] keys_held, [11] servo_updated,
  // [19:12] angle, [35:20] compare_value, [39:36] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic              accepted, servo_updated;
  logic [KeyW-1:0]   key_code;
  logic [1:0]        keys_held;
  logic [AngleW-1:0] angle;
  logic [CmpW-1:0]   compare_value;

  kaes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kaes_dp #(
    .ENTRY_LENGTH (ENTRY_LENGTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .time_ms_i       (s_axis_tdata_i[31:0]),
    .column_i        (s_axis_tdata_i[33:32]),
    .row_sense_i     (s_axis_tdata_i[37:34]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .accepted_o      (accepted),
    .key_code_o      (key_code),
    .keys_held_o     (keys_held),
    .servo_updated_o (servo_updated),
    .angle_o         (angle),
    .compare_value_o (compare_value)
  );

  assign m_axis_tdata_o = {4'd0, compare_value, angle, servo_updated, keys_held,
                           key_code, accepted};

endmodule

>>> verif/keypad_angle_entry_servo_test.sv
`timescale 1ns / 1ps

module keypad_angle_entry_servo_test
  import kaes_pkg::*;
();

  localparam int unsigned ENTRY_LEN  = 3;
  localparam int unsigned QUIET_MAX  = 2000;
  localparam logic [7:0]  CH_HASH    = "#";
  localparam logic [7:0]  CH_STAR    = "*";
  localparam logic [7:0]  CH_ZERO    = "0";
  localparam logic [7:0]  CH_NINE    = "9";
  localparam logic [7:0]  CH_A       = "A";
  localparam int unsigned ANGLE_TOP  = 180;
  // rows 0..3 left to right, columns 0..3 within each row
  localparam logic [127:0] KEY_GRID  = "DCBA#9630852*741";

  typedef struct packed {
    logic [15:0] cmp;
    logic [7:0]  angle;
    logic        upd;
    logic [1:0]  held;
    logic [7:0]  key;
    logic        acc;
  } servo_word_t;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_ready = 1'b0;
  logic                cfg_we = 1'b0;
  cfg_idx_e            cfg_idx = CFG_DEBOUNCE;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_ready;
  logic                m_valid;
  logic [OutDataW-1:0] m_data;

  // shadow of the block's registers and state
  logic [15:0] deb_ms     = 16'd10;
  logic [14:0] pulse_off  = 15'd250;
  logic [14:0] pulse_span = 15'd999;
  logic [31:0] last_ms    = '0;
  logic [7:0]  cur_key    = '0;
  logic [7:0]  entry_buf [ENTRY_LEN];
  int unsigned entry_len  = 0;
  logic [7:0]  held_angle = '0;
  logic [15:0] held_cmp   = '0;

  servo_word_t expected_words[$];
  int unsigned sent      = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idling    = 1'b1;

  keypad_angle_entry_servo dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] key_at(input int unsigned r, input int unsigned c);
    return KEY_GRID[127 - 8 * (4 * r + c) -: 8];
  endfunction

  function automatic servo_word_t decode_event(input logic [31:0] t, input logic [1:0] col,
                                               input logic [3:0] rows);
    servo_word_t w;
    logic [31:0] gap;
    int unsigned val;
    bit          stop;
    w   = '0;
    gap = t - last_ms;
    if (gap > {16'd0, deb_ms}) begin
      w.acc   = 1'b1;
      last_ms = t;
      // highest set row wins, no row repeats the previous key
      for (int r = 0; r < 4; r++) begin
        if (rows[r]) cur_key = key_at(r, col);
      end
      if (entry_len < ENTRY_LEN) begin
        entry_buf[entry_len] = cur_key;
        entry_len++;
      end
      if (entry_len == ENTRY_LEN && cur_key == CH_HASH) begin
        val  = 0;
        stop = 1'b0;
        for (int i = 0; i < ENTRY_LEN; i++) begin
          if (!stop && entry_buf[i] >= CH_ZERO && entry_buf[i] <= CH_NINE)
            val = val * 10 + (entry_buf[i] - CH_ZERO);
          else
            stop = 1'b1;
        end
        if (val > ANGLE_TOP) val = ANGLE_TOP;
        held_angle = 8'(val);
        held_cmp   = 16'(pulse_off + (val * pulse_span) / ANGLE_TOP);
        for (int i = 0; i < ENTRY_LEN; i++) entry_buf[i] = '0;
        entry_len = 0;
        w.upd     = 1'b1;
      end
    end
    w.key   = cur_key;
    w.held  = entry_len[1:0];
    w.angle = held_angle;
    w.cmp   = held_cmp;
    return w;
  endfunction

  task automatic send_event(input logic [31:0] t, input logic [1:0] col, input logic [3:0] rows);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {2'b00, rows, col, t};
    do @(posedge clk_i); while (!s_ready);
    expected_words.push_back(decode_event(t, col, rows));
    sent++;
  endtask

  task automatic drain_words();
    s_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] deb, input logic [14:0] off,
                            input logic [14:0] span);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk_i);
    cfg_idx   <= CFG_OFFSET;
    cfg_wdata <= {1'b0, off};
    @(posedge clk_i);
    cfg_idx   <= CFG_SPAN;
    cfg_wdata <= {1'b0, span};
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    deb_ms     = deb;
    pulse_off  = off;
    pulse_span = span;
  endtask

  // press a key so that it clears the debounce gap, or bounces inside it
  task automatic press_key(input logic [7:0] k, input bit clears_gap);
    logic [1:0]  r;
    logic [1:0]  c;
    logic [3:0]  lower;
    logic [3:0]  rows;
    logic [31:0] t;
    r = '0;
    c = '0;
    for (int i = 0; i < 16; i++) begin
      if (key_at(i / 4, i % 4) == k) begin
        r = 2'(i / 4);
        c = 2'(i % 4);
      end
    end
    lower = 4'($urandom_range(0, 15));
    rows  = (4'b0001 << r) | (lower & ((4'b0001 << r) - 4'b0001));
    if (clears_gap)
      t = last_ms + deb_ms + 32'd1 + $urandom_range(0, 40);
    else
      t = last_ms + $urandom_range(0, deb_ms);
    send_event(t, c, rows);
  endtask

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 2))
      0:       return CH_STAR;
      1:       return CH_HASH;
      default: return 8'(CH_A + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic random_entry();
    int unsigned n;
    logic [7:0]  k;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0)
        k = pick_symbol();
      else if (i == 0 && $urandom_range(0, 1) == 1)
        k = "1";
      else
        k = 8'(CH_ZERO + $urandom_range(0, 9));
      if ($urandom_range(0, 9) == 0) press_key(k, 1'b0);
      press_key(k, 1'b1);
    end
    if ($urandom_range(0, 5) == 0) press_key(pick_symbol(), 1'b1);
    press_key(CH_HASH, 1'b1);
    if ($urandom_range(0, 7) == 0)
      send_event(last_ms + deb_ms + 32'd1, 2'($urandom_range(0, 3)), 4'b0000);
  endtask

  task automatic random_noise();
    logic [31:0] t;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 3))
        0:       t = last_ms + deb_ms;
        1:       t = last_ms + deb_ms + 32'd1;
        default: t = $urandom;
      endcase
      send_event(t, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_reset_state();
    send_event(32'd5, 2'd0, 4'b0001);   // too soon after reset
    send_event(32'd10, 2'd0, 4'b0001);  // gap equals debounce
    send_event(32'd11, 2'd2, 4'b0000);  // no row before any decode stores code zero
    send_event(32'd30, 2'd1, 4'b1111);
    send_event(32'd50, 2'd3, 4'b0011);
    send_event(32'd70, 2'd2, 4'b0001);  // buffer full, dropped
    send_event(32'd90, 2'd0, 4'b0010);  // hash with no leading digit
    press_key("1", 1'b1);
    press_key("8", 1'b1);
    press_key("5", 1'b1);
    press_key(CH_HASH, 1'b1);           // clamps to the top angle
  endtask

  task automatic test_time_wrap();
    send_event(32'hFFFF_FFF8, 2'd3, 4'b1000);
    send_event(32'd3, 2'd1, 4'b0000);
    send_event(32'd13, 2'd1, 4'b0100);
  endtask

  task automatic test_register_extremes();
    drain_words();
    set_config(16'd0, 15'd0, 15'd0);
    press_key("9", 1'b0);
    press_key("9", 1'b1);
    press_key(CH_HASH, 1'b1);
    drain_words();
    set_config(16'hFFFF, 15'h7FFF, 15'h7FFF);
    press_key("1", 1'b1);
    press_key("8", 1'b1);
    press_key("0", 1'b1);
    press_key(CH_HASH, 1'b1);
  endtask

  task automatic test_random_entries();
    int unsigned goal;
    bit          held_off;
    for (int ph = 0; ph < 5; ph++) begin
      drain_words();
      case (ph)
        0:       set_config(16'd0, 15'd0, 15'($urandom_range(0, 32767)));
        1:       set_config(16'hFFFF, 15'h7FFF, 15'h7FFF);
        4:       set_config(16'd10, 15'd250, 15'd999);
        default: set_config(16'($urandom_range(0, 300)), 15'($urandom_range(0, 32767)),
                            15'($urandom_range(0, 32767)));
      endcase
      if (ph == 4) idling = 1'b0;
      goal     = sent + 140;
      held_off = 1'b0;
      while (sent < goal) begin
        // sender waits for every word mid-phase
        if (!held_off && sent + 70 >= goal) begin
          drain_words();
          held_off = 1'b1;
        end
        if ($urandom_range(0, 9) < 2)
          random_noise();
        else
          random_entry();
      end
    end
  endtask

  initial begin
    forever begin
      if (idling && $urandom_range(0, 2) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  initial begin
    servo_word_t got;
    servo_word_t want;
    forever begin
      @(posedge clk_i);
      if (rst_n && m_valid && m_ready) begin
        got = m_data[35:0];
        if (expected_words.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_words.pop_front();
          if (got.acc !== want.acc || got.key !== want.key || got.held !== want.held ||
              got.upd !== want.upd || got.angle !== want.angle || got.cmp !== want.cmp) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: want acc=%0d key=%0d held=%0d upd=%0d angle=%0d cmp=%0d,%s",
                       want.acc, want.key, want.held, want.upd, want.angle, want.cmp,
                       $sformatf(" got acc=%0d key=%0d held=%0d upd=%0d angle=%0d cmp=%0d",
                                 got.acc, got.key, got.held, got.upd, got.angle, got.cmp));
          end
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_MAX) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < ENTRY_LEN; i++) entry_buf[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_time_wrap();
    test_register_extremes();
    test_random_entries();
    drain_words();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && expected_words.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
